### rtl/core/frame_rotate_by_quarter_turns_macros.svh
// Assertion macros for the quarter-turn frame rotator.
// Used by the top level; no other dependencies.
`ifndef FRAME_ROTATE_BY_QUARTER_TURNS_MACROS_SVH
`define FRAME_ROTATE_BY_QUARTER_TURNS_MACROS_SVH
`ifndef SYNTHESIS
`define FRQT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame rotator check failed");
`define FRQT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame rotator check failed");
`else
`define FRQT_ASSERT_IMP(lbl, ante, cons)
`define FRQT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/core/frqt_pkg.sv
// Shared types and constants for the quarter-turn frame rotator.
// No dependencies.
`timescale 1ns / 1ps
package frqt_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;
  localparam int unsigned DIM_RST        = 256;
  localparam int unsigned CFG_DATA_W     = 9;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned PIX_W          = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef struct packed {
    logic capture;
    logic addr_mul;
    logic write;
    logic total_mul;
    logic read;
    logic push;
  } frqt_cmd_t;

  typedef struct packed {
    logic out_free;
  } frqt_status_t;

endpackage

### rtl/core/frame_rotate_by_quarter_turns.sv
// Load request: address multiply, then store write, then the next request can be taken.
// Read request: frame size multiply, store read, then output load into the output
// register; the next request is taken after the output load, later while a previous
// result is stalled; one request at a time.
// Output register lets a new request enter while a result waits to be taken.
// Reset (async, active low) clears counters, control and config to defaults;
// the frame store is not cleared.
`timescale 1ns / 1ps
`include "frame_rotate_by_quarter_turns_macros.svh"
module frame_rotate_by_quarter_turns #(
  parameter int unsigned MAX_WIDTH  = frqt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frqt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [frqt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frqt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [frqt_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [frqt_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            last_o
);
  import frqt_pkg::*;

  frqt_cmd_t    cmd;
  frqt_status_t status;

  assign cfg_ready_o = 1'b1;

  frqt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  frqt_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .pixel_in_i  (pixel_in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .last_o      (last_o)
  );

  `FRQT_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `FRQT_ASSERT_IMP(a_push_only_when_free, cmd.push, status.out_free)
  `FRQT_ASSERT_IMP(a_one_command, 1'b1, $onehot0(cmd))
  `FRQT_ASSERT_NXT(a_push_shows_result, cmd.push, out_valid_o)

endmodule

### rtl/core/frqt_ctrl.sv
// Sequencer for the quarter-turn frame rotator.
// Depends on frqt_pkg for the command and status types.
`timescale 1ns / 1ps
module frqt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 action_i,
  output logic                 in_stall_o,
  input  frqt_pkg::frqt_status_t status_i,
  output frqt_pkg::frqt_cmd_t  cmd_o
);
  import frqt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LMUL  = 3'd1;
  localparam logic [2:0] S_LWR   = 3'd2;
  localparam logic [2:0] S_RMUL  = 3'd3;
  localparam logic [2:0] S_RADDR = 3'd4;
  localparam logic [2:0] S_RPUSH = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (action_i == ACT_READ) ? S_RMUL : S_LMUL;
        end
      end
      S_LMUL: begin
        cmd_o.addr_mul = 1'b1;
        state_d = S_LWR;
      end
      S_LWR: begin
        cmd_o.write = 1'b1;
        state_d = S_IDLE;
      end
      S_RMUL: begin
        cmd_o.total_mul = 1'b1;
        state_d = S_RADDR;
      end
      S_RADDR: begin
        cmd_o.read = 1'b1;
        state_d = S_RPUSH;
      end
      S_RPUSH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/frqt_dp.sv
// Datapath of the quarter-turn frame rotator: registers, counters,
// address multiplier, frame store and output register. Uses frqt_pkg.
`timescale 1ns / 1ps
module frqt_dp #(
  parameter int unsigned MAX_WIDTH  = frqt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = frqt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [frqt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frqt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            action_i,
  input  logic [frqt_pkg::PIX_W-1:0]      pixel_in_i,
  input  frqt_pkg::frqt_cmd_t             cmd_i,
  output frqt_pkg::frqt_status_t          status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [frqt_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            last_o
);
  import frqt_pkg::*;

  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned CW      = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int unsigned PW      = 2 * DIM_W;
  localparam int unsigned DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned TW      = AW + 1;
  localparam int unsigned RW      = $clog2(MAX_HEIGHT);
  localparam int unsigned CLW     = $clog2(MAX_WIDTH);
  localparam int unsigned W_RST   = (DIM_RST > MAX_WIDTH) ? MAX_WIDTH : DIM_RST;
  localparam int unsigned H_RST   = (DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RST;

  logic [1:0]       rot_q;
  logic [DIM_W-1:0] w_q, h_q;
  logic [CW-1:0]    cfg_ext, w_clamp, h_clamp;

  logic             act_q;
  logic [PIX_W-1:0] pix_q;
  logic [RW-1:0]    row_q;
  logic [CLW-1:0]   col_q;
  logic [AW-1:0]    ridx_q;
  logic [PW-1:0]    prod_q;
  logic [DIM_W-1:0] off_q;
  logic [TW-1:0]    total_q;
  logic [PIX_W-1:0] rd_q;
  logic             rd_last_q;
  logic             out_valid_q;
  logic [PIX_W-1:0] pixel_out_q;
  logic             last_q;

  logic [DIM_W-1:0] row_eff, col_eff, row_inc, col_inc;
  logic [DIM_W-1:0] mul_a, mul_b, mul_c;
  logic [PW-1:0]    addr_sum, total_prod;
  logic [AW-1:0]    waddr, ridx_eff;
  logic [TW-1:0]    ridx_inc;

  logic [PIX_W-1:0] store [DEPTH];

  // Dimension clamp: zero reads as one, anything above the maximum as the maximum
  assign cfg_ext = CW'(cfg_data_i);
  assign w_clamp = (cfg_ext == '0) ? CW'(1) :
                   (cfg_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : cfg_ext;
  assign h_clamp = (cfg_ext == '0) ? CW'(1) :
                   (cfg_ext > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : cfg_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= ROT_0;
      w_q   <= DIM_W'(W_RST);
      h_q   <= DIM_W'(H_RST);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROTATION: rot_q <= cfg_data_i[1:0];
        REG_WIDTH:    w_q   <= w_clamp[DIM_W-1:0];
        REG_HEIGHT:   h_q   <= h_clamp[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Counters left outside a shrunk frame wrap to zero
  assign row_eff = (DIM_W'(row_q) >= h_q) ? '0 : DIM_W'(row_q);
  assign col_eff = (DIM_W'(col_q) >= w_q) ? '0 : DIM_W'(col_q);
  assign row_inc = row_eff + DIM_W'(1);
  assign col_inc = col_eff + DIM_W'(1);

  always_comb begin
    case (rot_q)
      ROT_0: begin
        mul_a = row_eff;
        mul_b = w_q;
        mul_c = col_eff;
      end
      ROT_90: begin
        mul_a = w_q - DIM_W'(1) - col_eff;
        mul_b = h_q;
        mul_c = row_eff;
      end
      ROT_180: begin
        mul_a = h_q - DIM_W'(1) - row_eff;
        mul_b = w_q;
        mul_c = w_q - DIM_W'(1) - col_eff;
      end
      ROT_270: begin
        mul_a = col_eff;
        mul_b = h_q;
        mul_c = h_q - DIM_W'(1) - row_eff;
      end
      default: begin
        mul_a = row_eff;
        mul_b = w_q;
        mul_c = col_eff;
      end
    endcase
  end

  assign addr_sum   = prod_q + PW'(off_q);
  assign waddr      = addr_sum[AW-1:0];
  assign total_prod = PW'(w_q) * PW'(h_q);

  assign ridx_eff = ({1'b0, ridx_q} >= total_q) ? '0 : ridx_q;
  assign ridx_inc = TW'(ridx_eff) + TW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      pix_q <= pixel_in_i;
    end
    if (cmd_i.addr_mul) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
      off_q  <= mul_c;
    end
    if (cmd_i.total_mul) begin
      total_q <= total_prod[TW-1:0];
    end
    if (cmd_i.read) begin
      rd_last_q <= (ridx_inc == total_q);
    end
    if (cmd_i.push) begin
      pixel_out_q <= rd_q;
      last_q      <= rd_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (act_q == ACT_LOAD)) begin
      store[waddr] <= pix_q;
    end
    if (cmd_i.read) begin
      rd_q <= store[ridx_eff];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ridx_q <= '0;
    end else begin
      if (cmd_i.write) begin
        if (col_inc >= w_q) begin
          col_q <= '0;
          row_q <= (row_inc >= h_q) ? '0 : row_inc[RW-1:0];
        end else begin
          col_q <= col_inc[CLW-1:0];
          row_q <= row_eff[RW-1:0];
        end
      end
      if (cmd_i.read) begin
        ridx_q <= (ridx_inc >= total_q) ? '0 : ridx_inc[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign pixel_out_o       = pixel_out_q;
  assign last_o            = last_q;

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_rotate_by_quarter_turns: a scoreboard keeps its own
// rotated frame store and checks each read request result against it.
// Depends on frqt_pkg and the frame rotator RTL.

import frqt_pkg::*;

typedef struct packed {
  logic [PIX_W-1:0] pixel;
  logic             last;
} rotated_pixel_t;

class rotator_scoreboard;
  logic [1:0]       quarter_turns;
  logic [8:0]       frame_w;
  logic [8:0]       frame_h;
  logic [7:0]       load_row;
  logic [7:0]       load_col;
  logic [15:0]      read_index;
  logic [PIX_W-1:0] shadow_store [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
  bit               loaded [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
  rotated_pixel_t   awaited_pixels [$];
  int               mismatches;

  function new();
    quarter_turns = ROT_0;
    frame_w       = 9'(DIM_RST);
    frame_h       = 9'(DIM_RST);
    load_row      = '0;
    load_col      = '0;
    read_index    = '0;
    mismatches    = 0;
  endfunction

  function logic [8:0] clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned maxv);
    if (v == 0) return 9'd1;
    if (v > maxv) return maxv[8:0];
    return v;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ROTATION: quarter_turns = data[1:0];
      REG_WIDTH:    frame_w = clamp_dim(data, MAX_WIDTH_DEF);
      REG_HEIGHT:   frame_h = clamp_dim(data, MAX_HEIGHT_DEF);
      default: ;
    endcase
  endfunction

  function int unsigned frame_pixels();
    int unsigned w;
    int unsigned h;
    w = frame_w;
    h = frame_h;
    return w * h;
  endfunction

  // read pointer wraps first if the frame has shrunk under it
  function int unsigned next_read_slot();
    int unsigned slot;
    slot = read_index;
    return (slot >= frame_pixels()) ? 0 : slot;
  endfunction

  function bit readable();
    return loaded[next_read_slot()];
  endfunction

  function void note_request(logic act, logic [PIX_W-1:0] pix);
    int unsigned    w;
    int unsigned    h;
    int unsigned    r;
    int unsigned    c;
    int unsigned    addr;
    int unsigned    slot;
    rotated_pixel_t res;
    w = frame_w;
    h = frame_h;
    if (act == ACT_LOAD) begin
      r = (load_row >= h) ? 0 : load_row;
      c = (load_col >= w) ? 0 : load_col;
      case (quarter_turns)
        ROT_90:  addr = (w - 1 - c) * h + r;
        ROT_180: addr = (h - 1 - r) * w + w - 1 - c;
        ROT_270: addr = c * h + h - 1 - r;
        default: addr = r * w + c;
      endcase
      shadow_store[addr] = pix;
      loaded[addr] = 1'b1;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      load_row = r[7:0];
      load_col = c[7:0];
    end else begin
      slot = next_read_slot();
      res.pixel = shadow_store[slot];
      res.last  = (slot == w * h - 1);
      slot++;
      if (slot >= w * h) slot = 0;
      read_index = slot[15:0];
      awaited_pixels.push_back(res);
    end
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 50) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_result(logic [PIX_W-1:0] pix, logic last);
    rotated_pixel_t exp_px;
    if (awaited_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected result: pixel %h last %b", pix, last));
      return;
    end
    exp_px = awaited_pixels.pop_front();
    if (pix !== exp_px.pixel)
      report_mismatch($sformatf("pixel_out %h, expected %h", pix, exp_px.pixel));
    if (last !== exp_px.last)
      report_mismatch($sformatf("last %b, expected %b", last, exp_px.last));
  endtask
endclass

module tb;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 700;
  localparam int STEADY_FROM    = 620;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  action_i    = ACT_LOAD;
  logic [PIX_W-1:0]      pixel_in_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      pixel_out_o;
  logic                  last_o;

  rotator_scoreboard sb = new();
  int requests_sent = 0;
  bit steady        = 1'b0;
  int stall_left    = 0;
  int stuck_cycles  = 0;

  frame_rotate_by_quarter_turns u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_out_o (pixel_out_o),
    .last_o      (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // random output stall bursts, none once steady
  always @(posedge clk_i) begin
    if (steady) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(pixel_out_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_req(logic act, logic [PIX_W-1:0] pix);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, pix);
    requests_sent++;
    if (requests_sent >= STEADY_FROM) steady = 1'b1;
  endtask

  // a read is only issued once its store entry has been loaded
  task automatic send_random(bit want_read);
    logic [PIX_W-1:0] pix;
    case ($urandom_range(0, 9))
      0: pix = '0;
      1: pix = '1;
      default: pix = $urandom;
    endcase
    if (want_read && sb.readable()) send_req(ACT_READ, pix);
    else send_req(ACT_LOAD, pix);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.awaited_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [1:0] rot, logic [CFG_DATA_W-1:0] wd,
                           logic [CFG_DATA_W-1:0] hd, bit spare);
    settle();
    write_reg(REG_ROTATION, {(CFG_DATA_W-2)'($urandom), rot});
    write_reg(REG_WIDTH, wd);
    write_reg(REG_HEIGHT, hd);
    if (spare) write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_dim();
    if ($urandom_range(0, 15) == 0) return '0;
    return CFG_DATA_W'($urandom_range(1, 12));
  endfunction

  // framed: whole frames loaded then read back, with a little noise mixed in
  task automatic run_phase(int n, bit framed);
    int          k;
    int unsigned span;
    int unsigned loads_left;
    int unsigned reads_left;
    span       = sb.frame_pixels();
    loads_left = 0;
    reads_left = 0;
    for (k = 0; k < n; k++) begin
      if (!framed || $urandom_range(0, 9) == 0) begin
        send_random(1'($urandom_range(0, 1)));
      end else begin
        if (loads_left == 0 && reads_left == 0) begin
          loads_left = span;
          reads_left = span;
        end
        if (loads_left > 0) begin
          loads_left--;
          send_random(1'b0);
        end else begin
          reads_left--;
          send_random(1'b1);
        end
      end
    end
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(ROT_90, 9'd3, 9'd2, 1'b1);
    send_req(ACT_LOAD, 32'h0000_0000);
    send_req(ACT_LOAD, 32'hFFFF_FFFF);
    send_req(ACT_LOAD, 32'hAAAA_AAAA);
    send_req(ACT_LOAD, 32'h5555_5555);
    send_req(ACT_LOAD, 32'h0000_0001);
    send_req(ACT_LOAD, 32'h8000_0000);
    for (k = 0; k < 6; k++) send_req(ACT_READ, '0);
    configure(ROT_0, 9'd3, 9'd2, 1'b0);
    for (k = 0; k < 3; k++) send_random(1'b0);
    // rotation changed half way through the frame
    configure(ROT_180, 9'd3, 9'd2, 1'b0);
    for (k = 0; k < 3; k++) send_random(1'b0);
    for (k = 0; k < 6; k++) send_req(ACT_READ, '1);

    // extreme and out-of-range frame sizes
    configure(ROT_0, 9'd256, 9'd1, 1'b0);
    run_phase(40, 1'b0);
    configure(ROT_90, 9'd1, 9'd256, 1'b0);
    run_phase(40, 1'b0);
    configure(ROT_270, 9'h1FF, 9'd0, 1'b0);
    run_phase(40, 1'b0);
    configure(ROT_180, 9'd0, 9'd0, 1'b1);
    run_phase(20, 1'b1);
    configure(ROT_90, 9'd1, 9'h1FF, 1'b0);
    run_phase(30, 1'b0);

    while (requests_sent < ITEM_TARGET) begin
      configure(2'($urandom_range(0, 3)), rand_dim(), rand_dim(), $urandom_range(0, 3) == 0);
      run_phase($urandom_range(30, 80), $urandom_range(0, 3) != 0);
    end

    settle();
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/frqt_pkg.sv
rtl/core/frqt_ctrl.sv
rtl/core/frqt_dp.sv
rtl/core/frame_rotate_by_quarter_turns.sv
test/tb.sv
